// ===== rtl/pxalu_pkg.sv =====
package pxalu_pkg;

    localparam int FieldW = 17;
    localparam int RawW   = 35;
    localparam int NumW   = 20;
    localparam int DenW   = 19;
    localparam int DivStages = 5;
    localparam int BitsPerStage = NumW / DivStages;

    typedef enum logic [2:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_DIV = 3'd3,
        ACT_ABS = 3'd4,
        ACT_CMP = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        CLS_U8  = 2'd0,
        CLS_U16 = 2'd1,
        CLS_I16 = 2'd2,
        CLS_LOG = 2'd3
    } pclass_t;

    localparam logic [2:0] REG_PIXEL_CLASS = 3'd0;

    typedef struct packed {
        logic                   valid;
        logic [2:0]             action;
        logic [1:0]             cls;
        logic signed [RawW-1:0] raw;
        logic                   neg;
        logic                   xpos;
        logic                   xneg;
        logic                   yzero;
    } side_t;

    typedef struct packed {
        logic [NumW-1:0] n;
        logic [DenW-1:0] d;
        logic [NumW-1:0] r;
        logic [NumW-1:0] q;
    } div_t;

    function automatic logic signed [FieldW-1:0] saturate(
        input logic signed [RawW-1:0] v, input logic [1:0] cls);
        logic signed [RawW-1:0] lo;
        logic signed [RawW-1:0] hi;
        logic signed [RawW-1:0] c;
        begin
            case (cls)
                CLS_U8:  begin lo = '0; hi = RawW'(255); end
                CLS_U16: begin lo = '0; hi = RawW'(65535); end
                CLS_I16: begin lo = -RawW'(32768); hi = RawW'(32767); end
                default: begin lo = '0; hi = RawW'(255); end
            endcase
            c = v;
            if (c < lo) c = lo;
            if (c > hi) c = hi;
            if (cls == CLS_LOG) c = (c != '0) ? RawW'(1) : '0;
            saturate = c[FieldW-1:0];
        end
    endfunction

    function automatic logic signed [RawW-1:0] class_top(input logic [1:0] cls);
        begin
            case (cls)
                CLS_U8:  class_top = RawW'(255);
                CLS_U16: class_top = RawW'(65535);
                CLS_I16: class_top = RawW'(32767);
                default: class_top = RawW'(1);
            endcase
        end
    endfunction

endpackage

// ===== rtl/pxalu_div_stage.sv =====
module pxalu_div_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  pxalu_pkg::side_t   side_in,
    input  pxalu_pkg::div_t    div_in,
    output pxalu_pkg::side_t   side_out,
    output pxalu_pkg::div_t    div_out
);
    import pxalu_pkg::*;

    div_t  div_next;
    side_t side_reg;
    div_t  div_reg;

    // restoring steps, one quotient bit each
    always_comb
    begin
        div_next = div_in;
        for (int i = 0; i < BitsPerStage; i++)
        begin
            div_next.r = {div_next.r[NumW-2:0], div_next.n[NumW-1]};
            div_next.n = {div_next.n[NumW-2:0], 1'b0};
            if (div_next.r >= NumW'(div_next.d))
            begin
                div_next.r = div_next.r - NumW'(div_next.d);
                div_next.q = {div_next.q[NumW-2:0], 1'b1};
            end
            else
            begin
                div_next.q = {div_next.q[NumW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
            div_reg  <= '0;
        end
        else if (en)
        begin
            side_reg <= side_in;
            div_reg  <= div_next;
        end
    end

    assign side_out = side_reg;
    assign div_out  = div_reg;

endmodule

// ===== rtl/saturating_pixel_alu.sv =====
// Saturating pixel ALU: takes one item per clock (action, x, y) and returns the
// result saturated to pixel_class through seven register stages. The stages are
// one operand stage (add, subtract, absolute difference, compare, magnitudes and
// the 17x17 multiply), five stages of the restoring divider at four quotient bits
// each, and the saturating output register. The whole pipe holds when a waiting
// result is not taken; pixel_class should be written only when idle.
module saturating_pixel_alu (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // action[2:0], x_value[19:3], y_value[36:20]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // result_value[16:0]
);
    import pxalu_pkg::*;

    logic [1:0] cls_reg;
    logic       en;

    logic [2:0]               act_in;
    logic signed [FieldW-1:0] x_in;
    logic signed [FieldW-1:0] y_in;
    logic [FieldW-1:0]        ma;
    logic [FieldW-1:0]        mb;

    side_t side_next;
    div_t  div_next;
    side_t side_reg;
    div_t  div_reg;
    side_t side_pipe [DivStages+1];
    div_t  div_pipe  [DivStages+1];

    logic signed [RawW-1:0]   val;
    logic signed [FieldW-1:0] res_next;
    logic                     out_valid_reg;
    logic signed [FieldW-1:0] res_reg;

    assign pready = 1'b1;
    assign prdata = {30'd0, cls_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cls_reg <= CLS_U8;
        end
        else if (psel && penable && pwrite && paddr == REG_PIXEL_CLASS)
        begin
            cls_reg <= pwdata[1:0];
        end
    end

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    assign act_in = s_tdata[2:0];
    assign x_in   = s_tdata[19:3];
    assign y_in   = s_tdata[36:20];
    assign ma     = x_in[FieldW-1] ? FieldW'(-x_in) : FieldW'(x_in);
    assign mb     = y_in[FieldW-1] ? FieldW'(-y_in) : FieldW'(y_in);

    always_comb
    begin
        side_next.valid  = s_tvalid;
        side_next.action = act_in;
        side_next.cls    = cls_reg;
        side_next.neg    = x_in[FieldW-1] != y_in[FieldW-1];
        side_next.xpos   = !x_in[FieldW-1] && x_in != '0;
        side_next.xneg   = x_in[FieldW-1];
        side_next.yzero  = y_in == '0;
        case (act_in)
            ACT_ADD: side_next.raw = RawW'(x_in) + RawW'(y_in);
            ACT_SUB: side_next.raw = RawW'(x_in) - RawW'(y_in);
            ACT_MUL: side_next.raw = RawW'(x_in * y_in);
            ACT_ABS: side_next.raw = (x_in >= y_in) ? RawW'(x_in) - RawW'(y_in)
                                                    : RawW'(y_in) - RawW'(x_in);
            ACT_CMP: side_next.raw = class_top(cls_reg) - RawW'(x_in);
            default: side_next.raw = '0;
        endcase
        div_next.n = NumW'({ma, 1'b0}) + NumW'(mb);
        div_next.d = DenW'({mb, 1'b0});
        div_next.r = '0;
        div_next.q = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
            div_reg  <= '0;
        end
        else if (en)
        begin
            side_reg <= side_next;
            div_reg  <= div_next;
        end
    end

    assign side_pipe[0] = side_reg;
    assign div_pipe[0]  = div_reg;

    for (genvar g = 0; g < DivStages; g++)
    begin : g_div
        pxalu_div_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .side_in  (side_pipe[g]),
            .div_in   (div_pipe[g]),
            .side_out (side_pipe[g+1]),
            .div_out  (div_pipe[g+1])
        );
    end

    always_comb
    begin
        val = side_pipe[DivStages].raw;
        if (side_pipe[DivStages].action == ACT_DIV)
        begin
            if (side_pipe[DivStages].yzero)
            begin
                if (side_pipe[DivStages].xpos)
                    val = RawW'(1) <<< 20;
                else if (side_pipe[DivStages].xneg)
                    val = -(RawW'(1) <<< 20);
                else
                    val = '0;
            end
            else if (side_pipe[DivStages].neg)
            begin
                val = -RawW'(div_pipe[DivStages].q);
            end
            else
            begin
                val = RawW'(div_pipe[DivStages].q);
            end
        end
        // unused codes already carry zero, which saturates to zero
        res_next = saturate(val, side_pipe[DivStages].cls);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= side_pipe[DivStages].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, res_reg};

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_logical_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && cls_reg == CLS_LOG) |-> (res_reg == 17'sd0 || res_reg == 17'sd1))
        else $error("logical result not 0 or 1");

    a_u8_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && cls_reg == CLS_U8) |-> (!res_reg[16] && res_reg[15:8] == 8'd0))
        else $error("uint8 result out of range");

endmodule
